### rtl/ttps_pkg.sv
`timescale 1ns / 1ps

package ttps_pkg;

    // Character codes used by the tag scanner.
    localparam logic [7:0] CH_LT      = 8'h3C;  // '<'
    localparam logic [7:0] CH_PCT     = 8'h25;  // '%'
    localparam logic [7:0] CH_GT      = 8'h3E;  // '>'
    localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
    localparam logic [7:0] CH_NL      = 8'h0A;  // newline
    localparam logic [7:0] CH_QUOTE   = 8'h22;  // double quote
    localparam logic [7:0] CH_APOS    = 8'h27;  // apostrophe
    localparam logic [7:0] CH_BSLASH  = 8'h5C;  // backslash

    // Lengths of the fixed output segments.
    localparam int LEAD_TEXT_LEN  = 18;
    localparam int LEAD_VALUE_LEN = 17;
    localparam int TAIL_NL_LEN    = 5;
    localparam int TAIL_BARE_LEN  = 3;
    localparam int VAL_END_LEN    = 2;

    localparam int IDX_W = $clog2(LEAD_TEXT_LEN);

    // One input byte expands to at most this many segment commands.
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_CODE  = 2'd1,
        MODE_VALUE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_LT   = 2'd1,
        HELD_PCT  = 2'd2,
        HELD_OPEN = 2'd3
    } held_t;

    typedef enum logic [2:0] {
        CMD_BYTE       = 3'd0,
        CMD_LEAD_TEXT  = 3'd1,
        CMD_LEAD_VALUE = 3'd2,
        CMD_TAIL_NL    = 3'd3,
        CMD_TAIL_BARE  = 3'd4,
        CMD_VAL_END    = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
    } cmd_t;

    // All commands caused by one input transaction, slot 0 first.
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        cmd_t [SLOTS-1:0]      slot;
    } bundle_t;

    // Index of the final byte of a segment.
    function automatic logic [IDX_W-1:0] seg_last_idx(input cmd_kind_t kind);
        logic [IDX_W-1:0] r;
        unique case (kind)
            CMD_BYTE:       r = '0;
            CMD_LEAD_TEXT:  r = IDX_W'(LEAD_TEXT_LEN - 1);
            CMD_LEAD_VALUE: r = IDX_W'(LEAD_VALUE_LEN - 1);
            CMD_TAIL_NL:    r = IDX_W'(TAIL_NL_LEN - 1);
            CMD_TAIL_BARE:  r = IDX_W'(TAIL_BARE_LEN - 1);
            CMD_VAL_END:    r = IDX_W'(VAL_END_LEN - 1);
            default:        r = '0;
        endcase
        return r;
    endfunction

    // Call prefix: four spaces, the print routine name, "(ysc, " and a quote.
    function automatic logic [7:0] lead_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0, 5'd1, 5'd2, 5'd3: r = 8'h20;
            5'd4:    r = 8'h59;
            5'd5:    r = 8'h78;
            5'd6:    r = 8'h50;
            5'd7:    r = 8'h72;
            5'd8:    r = 8'h69;
            5'd9:    r = 8'h6E;
            5'd10:   r = 8'h74;
            5'd11:   r = 8'h28;
            5'd12:   r = 8'h79;
            5'd13:   r = 8'h73;
            5'd14:   r = 8'h63;
            5'd15:   r = 8'h2C;
            5'd16:   r = 8'h20;
            5'd17:   r = 8'h22;
            default: r = 8'h20;
        endcase
        return r;
    endfunction

    // Byte number idx of the segment that a command stands for.
    function automatic logic [7:0] seg_byte(input cmd_t cmd, input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        unique case (cmd.kind)
            CMD_BYTE:                      r = cmd.data;
            CMD_LEAD_TEXT, CMD_LEAD_VALUE: r = lead_byte(idx);
            CMD_TAIL_NL:
            begin
                unique case (idx)
                    5'd0:    r = CH_BSLASH;
                    5'd1:    r = 8'h6E;
                    5'd2:    r = CH_QUOTE;
                    5'd3:    r = 8'h29;
                    default: r = 8'h3B;
                endcase
            end
            CMD_TAIL_BARE:
            begin
                unique case (idx)
                    5'd0:    r = CH_QUOTE;
                    5'd1:    r = 8'h29;
                    default: r = 8'h3B;
                endcase
            end
            CMD_VAL_END:   r = (idx == '0) ? 8'h29 : 8'h3B;
            default:       r = cmd.data;
        endcase
        return r;
    endfunction

endpackage

### rtl/ttps_front.sv
`timescale 1ns / 1ps

module ttps_front
    import ttps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // end_of_input
    input  logic       q_full,
    output logic       q_push,
    output bundle_t    q_data
);

    typedef struct packed {
        mode_t   mode;
        held_t   held;
        logic    open;
        logic    niv;
        bundle_t b;
    } fst_t;

    function automatic fst_t f_push(input fst_t s, input cmd_kind_t kind, input logic [7:0] d);
        fst_t r;
        r = s;
        if (r.b.cnt < CNT_W'(SLOTS))
        begin
            r.b.slot[r.b.cnt[SLOT_W-1:0]] = '{kind: kind, data: d};
            r.b.cnt = r.b.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic fst_t f_content(input fst_t s, input logic [7:0] c);
        fst_t r;
        r = s;
        if (!r.open)
        begin
            if (r.mode == MODE_TEXT)
                r = f_push(r, CMD_LEAD_TEXT, c);
            else if (r.mode == MODE_VALUE)
                r = f_push(r, CMD_LEAD_VALUE, c);
            r.open = 1'b1;
        end
        r = f_push(r, CMD_BYTE, c);
        return r;
    endfunction

    function automatic fst_t f_plain(input fst_t s, input logic [7:0] c);
        fst_t r;
        r = s;
        if (r.mode == MODE_TEXT && (c == CH_QUOTE || c == CH_APOS || c == CH_BSLASH))
            r = f_content(r, CH_BSLASH);
        r = f_content(r, c);
        return r;
    endfunction

    function automatic fst_t f_close(input fst_t s, input mode_t nm);
        fst_t r;
        r = s;
        r.niv = (nm == MODE_VALUE);
        if (r.open)
        begin
            if (r.mode == MODE_TEXT)
                r = f_push(r, r.niv ? CMD_TAIL_BARE : CMD_TAIL_NL, CH_NL);
            else if (r.mode == MODE_VALUE)
                r = f_push(r, CMD_VAL_END, CH_NL);
            r = f_push(r, CMD_BYTE, CH_NL);
            r.open = 1'b0;
        end
        r.mode = nm;
        return r;
    endfunction

    function automatic fst_t f_feed(input fst_t s, input logic [7:0] c);
        fst_t r;
        logic done;
        r = s;
        done = 1'b0;
        if (r.held == HELD_LT)
        begin
            if (c == CH_PCT)
            begin
                r.held = HELD_OPEN;
                done = 1'b1;
            end
            else
            begin
                r.held = HELD_NONE;
                r = f_content(r, CH_LT);
            end
        end
        else if (r.held == HELD_PCT)
        begin
            r.held = HELD_NONE;
            if (c == CH_GT)
            begin
                r = f_close(r, MODE_TEXT);
                done = 1'b1;
            end
            else
                r = f_content(r, CH_PCT);
        end
        if (!done)
        begin
            if (c == CH_LT)
                r.held = HELD_LT;
            else if (c == CH_PCT)
                r.held = HELD_PCT;
            else if (c == CH_NL)
                r = f_close(r, r.mode);
            else
                r = f_plain(r, c);
        end
        return r;
    endfunction

    mode_t mode_reg, mode_next;
    held_t held_reg, held_next;
    logic  open_reg, open_next;
    logic  niv_reg, niv_next;
    logic  accept;
    fst_t  cur, nxt;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cur      = '0;
        cur.mode = mode_reg;
        cur.held = held_reg;
        cur.open = open_reg;
        cur.niv  = niv_reg;
        if (s_tlast)
        begin
            nxt = cur;
            if (cur.held == HELD_LT)
                nxt = f_content(nxt, CH_LT);
            else if (cur.held == HELD_PCT)
                nxt = f_content(nxt, CH_PCT);
            if (cur.held == HELD_OPEN)
                nxt = f_close(nxt, MODE_CODE);
            else
                nxt = f_close(nxt, nxt.mode);
            nxt.mode = MODE_TEXT;
            nxt.held = HELD_NONE;
            nxt.open = 1'b0;
            nxt.niv  = 1'b0;
        end
        else if (cur.held == HELD_OPEN)
        begin
            nxt      = cur;
            nxt.held = HELD_NONE;
            if (s_tdata == CH_EQ)
                nxt = f_close(nxt, MODE_VALUE);
            else
            begin
                nxt = f_close(nxt, MODE_CODE);
                nxt = f_feed(nxt, s_tdata);
            end
        end
        else
            nxt = f_feed(cur, s_tdata);
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        open_next = open_reg;
        niv_next  = niv_reg;
        if (accept)
        begin
            mode_next = nxt.mode;
            held_next = nxt.held;
            open_next = nxt.open;
            niv_next  = nxt.niv;
        end
    end

    assign q_push = accept && (nxt.b.cnt != '0);
    assign q_data = nxt.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            held_reg <= HELD_NONE;
            open_reg <= 1'b0;
            niv_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            open_reg <= open_next;
            niv_reg  <= niv_next;
        end
    end

    // A chunk is never open while a tag is half seen after an end of input.
    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (held_reg == HELD_NONE && !open_reg && mode_reg == MODE_TEXT))
        else $error("front state not cleared after end of input");

endmodule

### rtl/ttps_queue.sv
`timescale 1ns / 1ps

module ttps_queue
    import ttps_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    valid,
    output bundle_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    bundle_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

endmodule

### rtl/ttps_back.sv
`timescale 1ns / 1ps

module ttps_back
    import ttps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  bundle_t    q_data,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast      // last_of_run
);

    bundle_t             cur_reg, cur_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;
    cmd_t                cur_cmd;
    logic                seg_end, slot_end, out_free, advance, done;

    always_comb
    begin
        cur_cmd  = cur_reg.slot[slot_reg];
        seg_end  = (idx_reg == seg_last_idx(cur_cmd.kind));
        slot_end = ((CNT_W'(slot_reg) + CNT_W'(1)) == cur_reg.cnt);
        out_free = !m_tvalid_reg || m_tready;
        advance  = cur_valid_reg && out_free;
        done     = advance && seg_end && slot_end;
        q_pop    = q_valid && (!cur_valid_reg || done);
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        if (advance)
        begin
            if (!seg_end)
                idx_next = idx_reg + IDX_W'(1);
            else if (!slot_end)
            begin
                slot_next = slot_reg + SLOT_W'(1);
                idx_next  = '0;
            end
            else
                cur_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            slot_next      = '0;
            idx_next       = '0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_free)
        begin
            m_tvalid_next = advance;
            m_tdata_next  = seg_byte(cur_cmd, idx_reg);
            m_tlast_next  = seg_end && slot_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (CNT_W'(slot_reg) < cur_reg.cnt))
        else $error("segment slot beyond bundle count");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready && cur_valid_reg) |=> ($stable(slot_reg) && $stable(idx_reg)))
        else $error("expansion advanced while output stalled");

endmodule

### rtl/template_tag_to_print_stream.sv
`timescale 1ns / 1ps

// Channel | Dir | Ports                             | Payload
// --------+-----+-----------------------------------+-----------------------------------
// s_      | in  | s_tvalid s_tready s_tdata s_tlast | tdata in_byte, tlast end_of_input
// m_      | out | m_tvalid m_tready m_tdata m_tlast | tdata out_byte, tlast last_of_run
//
// An input transaction is accepted in any cycle in which the bundle queue has room, so
// bytes stream in back to back while earlier ones are still being expanded.
// The output side emits exactly one byte per cycle while m_tready is high and bytes
// are pending; each input item produces none to 25 output bytes, mostly 1 or 2.
// A stall on the input side holds only that side.
// The expansion unit in the back part is the limit on sustained rate. Reset is
// asynchronous and clears the scanner mode, the queue and the output register at once;
// there is no clearing pass. An output stall holds the input once the queue is full.

module template_tag_to_print_stream
    import ttps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast      // last_of_run
);

    // The front part scans tags and tracks the mode. For each input transaction it
    // produces a bundle of up to four segment commands (a literal byte, a call prefix,
    // or a chunk suffix). Transactions that produce nothing push no bundle.
    logic    q_full;
    logic    q_push;
    bundle_t q_push_data;
    logic    q_pop;
    logic    q_valid;
    bundle_t q_pop_data;

    ttps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // The queue decouples scanning from expansion, so bursts of prefix and suffix
    // bytes do not hold off the input until the queue is full.
    ttps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    // The back part walks each bundle segment by segment and byte by byte, and marks
    // the final byte of a bundle with tlast.
    ttps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### bench/tb_template_tag_to_print_stream.sv
`timescale 1ns / 1ps

module tb_template_tag_to_print_stream
    import ttps_pkg::*;
;

    // ------------------------------------------------------------------
    // Clock, reset and the two stream interfaces.
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic       s_tlast;    // end_of_input
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic       m_tlast;    // last_of_run

    template_tag_to_print_stream dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Fixed pieces of the generated source text.
    // ------------------------------------------------------------------

    // Print call prefix, first byte in the top bits: four spaces, the print
    // routine name, "(ysc, " and an opening quote. Value chunks use only the
    // first 17 bytes, leaving the quote off.
    localparam logic [18*8-1:0] CALL_HEAD = {
        8'h20, 8'h20, 8'h20, 8'h20, 8'h59, 8'h78, 8'h50, 8'h72, 8'h69,
        8'h6E, 8'h74, 8'h28, 8'h79, 8'h73, 8'h63, 8'h2C, 8'h20, 8'h22
    };
    localparam int TEXT_HEAD_LEN  = 18;
    localparam int VALUE_HEAD_LEN = 17;

    localparam logic [7:0] CH_N     = 8'h6E;   // 'n' of the newline escape
    localparam logic [7:0] CH_RPAR  = 8'h29;   // ')'
    localparam logic [7:0] CH_SEMI  = 8'h3B;   // ';'

    // ------------------------------------------------------------------
    // Scanner model: its own copy of the converter state.
    // ------------------------------------------------------------------
    mode_t gen_mode;
    held_t gen_held;
    logic  gen_chunk_open;
    logic  gen_next_value;

    // Bytes produced by the transaction being predicted, then the store of
    // expected output bytes, each entry {last_of_run, out_byte}.
    logic [7:0] step_bytes[$];
    logic [8:0] src_expect_q[$];

    // Count and final byte of the last prediction; the directed rows check them.
    int         step_n;
    logic [7:0] step_last;

    function automatic void clear_scanner();
        gen_mode       = MODE_TEXT;
        gen_held       = HELD_NONE;
        gen_chunk_open = 1'b0;
        gen_next_value = 1'b0;
    endfunction

    function automatic void put_call_head(input int len);
        for (int i = 0; i < len; i++)
            step_bytes.push_back(CALL_HEAD[8*(TEXT_HEAD_LEN-1-i) +: 8]);
    endfunction

    // A byte of chunk text; the first one of a chunk drags in the call prefix.
    function automatic void chunk_byte(input logic [7:0] b);
        if (!gen_chunk_open)
        begin
            if (gen_mode == MODE_TEXT)
                put_call_head(TEXT_HEAD_LEN);
            else if (gen_mode == MODE_VALUE)
                put_call_head(VALUE_HEAD_LEN);
            gen_chunk_open = 1'b1;
        end
        step_bytes.push_back(b);
    endfunction

    // Quote, apostrophe and backslash get escaped, but only in text mode.
    function automatic void text_byte(input logic [7:0] b);
        if (gen_mode == MODE_TEXT && (b == CH_QUOTE || b == CH_APOS || b == CH_BSLASH))
            chunk_byte(CH_BSLASH);
        chunk_byte(b);
    endfunction

    // Closes the current chunk and switches to the given mode. An empty chunk
    // leaves no trace in the output.
    function automatic void end_chunk(input mode_t nxt);
        gen_next_value = (nxt == MODE_VALUE);
        if (gen_chunk_open)
        begin
            if (gen_mode == MODE_TEXT)
            begin
                if (!gen_next_value)
                begin
                    step_bytes.push_back(CH_BSLASH);
                    step_bytes.push_back(CH_N);
                end
                step_bytes.push_back(CH_QUOTE);
                step_bytes.push_back(CH_RPAR);
                step_bytes.push_back(CH_SEMI);
            end
            else if (gen_mode == MODE_VALUE)
            begin
                step_bytes.push_back(CH_RPAR);
                step_bytes.push_back(CH_SEMI);
            end
            step_bytes.push_back(CH_NL);
            gen_chunk_open = 1'b0;
        end
        gen_mode = nxt;
    endfunction

    // One byte through the tag scanner. A held '<' or '%' that does not
    // complete a tag turns into plain chunk text, never escaped.
    function automatic void scan_byte(input logic [7:0] b);
        if (gen_held == HELD_LT)
        begin
            if (b == CH_PCT)
            begin
                gen_held = HELD_OPEN;
                return;
            end
            gen_held = HELD_NONE;
            chunk_byte(CH_LT);
        end
        else if (gen_held == HELD_PCT)
        begin
            gen_held = HELD_NONE;
            if (b == CH_GT)
            begin
                end_chunk(MODE_TEXT);
                return;
            end
            chunk_byte(CH_PCT);
        end
        if (b == CH_LT)
            gen_held = HELD_LT;
        else if (b == CH_PCT)
            gen_held = HELD_PCT;
        else if (b == CH_NL)
            end_chunk(gen_mode);
        else
            text_byte(b);
    endfunction

    // Works out every output byte that one input transaction causes and
    // appends them to the store of expected bytes.
    function automatic void expand_template_byte(input logic [7:0] b, input logic eoi);
        step_bytes.delete();
        if (eoi)
        begin
            // End of template: a held partial tag becomes text, a held "<%"
            // closes the chunk like the tag would, then everything starts over.
            if (gen_held == HELD_LT)
                chunk_byte(CH_LT);
            else if (gen_held == HELD_PCT)
                chunk_byte(CH_PCT);
            if (gen_held == HELD_OPEN)
                end_chunk(MODE_CODE);
            else
                end_chunk(gen_mode);
            clear_scanner();
        end
        else if (gen_held == HELD_OPEN)
        begin
            gen_held = HELD_NONE;
            if (b == CH_EQ)
                end_chunk(MODE_VALUE);
            else
            begin
                end_chunk(MODE_CODE);
                scan_byte(b);
            end
        end
        else
            scan_byte(b);

        step_n    = step_bytes.size();
        step_last = (step_n > 0) ? step_bytes[step_n-1] : 8'h00;
        for (int i = 0; i < step_n; i++)
            src_expect_q.push_back({(i == step_n - 1), step_bytes[i]});
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by the processes below.
    // ------------------------------------------------------------------
    int   errors       = 0;
    int   n_sent       = 0;
    int   n_templates  = 0;
    int   n_checked    = 0;
    logic gaps_on      = 1'b1;   // random idling on both sides
    int   stall_left   = 0;

    // ------------------------------------------------------------------
    // Input side. Called at a falling edge; returns at the falling edge that
    // follows the transaction. The valid stays high across back-to-back
    // transactions, so it gets one assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eoi);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        expand_template_byte(b, eoi);
        n_sent++;
        @(negedge clk);
    endtask

    // Template text for the random part: mostly printable characters, with
    // the tag and escape characters, newlines and arbitrary bytes mixed in.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] r;
        case ($urandom_range(0, 15))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       r = CH_QUOTE;
                    1:       r = CH_APOS;
                    2:       r = CH_BSLASH;
                    3:       r = CH_GT;
                    4:       r = CH_EQ;
                    default: r = CH_LT;
                endcase
            end
            1:       r = 8'($urandom_range(0, 255));
            2:       r = CH_NL;
            default: r = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        return r;
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_text_byte(), 1'b0);
    endtask

    // One template: text, code and value sections, newlines, sometimes a
    // missing close tag or a partial tag right before the end, and now and
    // then pure noise.
    task automatic send_template();
        int segs;
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(($urandom_range(0, 1) != 0) ? CH_LT : CH_PCT, 1'b0);
                else
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        else
        begin
            segs = $urandom_range(1, 5);
            repeat (segs)
            begin
                case ($urandom_range(0, 4))
                    0, 1: send_run($urandom_range(0, 8));
                    2, 3:
                    begin
                        send_item(CH_LT, 1'b0);
                        send_item(CH_PCT, 1'b0);
                        if ($urandom_range(0, 1) != 0)
                            send_item(CH_EQ, 1'b0);
                        send_run($urandom_range(0, 6));
                        if ($urandom_range(0, 5) != 0)
                        begin
                            send_item(CH_PCT, 1'b0);
                            send_item(CH_GT, 1'b0);
                        end
                    end
                    default: send_item(CH_NL, 1'b0);
                endcase
            end
            case ($urandom_range(0, 7))
                0: send_item(CH_LT, 1'b0);
                1: send_item(CH_PCT, 1'b0);
                2:
                begin
                    send_item(CH_LT, 1'b0);
                    send_item(CH_PCT, 1'b0);
                end
                default: ;
            endcase
        end
        // in_byte is ignored on the end marker, so it carries any value.
        send_item(8'($urandom_range(0, 255)), 1'b1);
        n_templates++;
    endtask

    // ------------------------------------------------------------------
    // Directed rows. Where the result is obvious, the row carries the number
    // of output bytes and the final byte; the rest rely on the scanner model.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] in_byte;
        logic       eoi;
        logic       typed;
        logic [4:0] n_out;
        logic [7:0] last_byte;
    } dir_row_t;

    localparam int N_DIR = 25;

    dir_row_t dir_rows [N_DIR] = '{
        // End marker straight after reset: nothing pending, nothing out.
        '{8'h00,     1'b1, 1'b1, 5'd0,  8'h00},
        // Lowest byte opens a text chunk: 18-byte prefix plus the byte.
        '{8'h00,     1'b0, 1'b1, 5'd19, 8'h00},
        '{8'hFF,     1'b0, 1'b1, 5'd1,  8'hFF},
        // A quote in text mode comes out escaped.
        '{CH_QUOTE,  1'b0, 1'b1, 5'd2,  CH_QUOTE},
        // A lone '<' is held back, then released as plain text.
        '{CH_LT,     1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h61,     1'b0, 1'b0, 5'd0,  8'h00},
        // A held '%' before a newline: the '%' is text, then the chunk closes.
        '{CH_PCT,    1'b0, 1'b1, 5'd0,  8'h00},
        '{CH_NL,     1'b0, 1'b0, 5'd0,  8'h00},
        // Value section: "<%=" then one byte then "%>".
        '{CH_LT,     1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_EQ,     1'b0, 1'b0, 5'd0,  8'h00},
        '{8'h78,     1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_GT,     1'b0, 1'b1, 5'd3,  CH_NL},
        // "<%%>" opens and closes an empty code section.
        '{CH_LT,     1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_GT,     1'b0, 1'b0, 5'd0,  8'h00},
        // A close tag while already in text mode.
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_GT,     1'b0, 1'b0, 5'd0,  8'h00},
        // "<%>" opens code and the '>' is code text.
        '{CH_LT,     1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_PCT,    1'b0, 1'b0, 5'd0,  8'h00},
        '{CH_GT,     1'b0, 1'b0, 5'd0,  8'h00},
        // End of template with a '<' still held flushes the code chunk.
        '{CH_LT,     1'b0, 1'b0, 5'd0,  8'h00},
        '{8'hA5,     1'b1, 1'b0, 5'd0,  8'h00}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed rows, random templates, drain.
    // ------------------------------------------------------------------
    initial
    begin
        int wait_cycles;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        clear_scanner();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            send_item(dir_rows[i].in_byte, dir_rows[i].eoi);
            if (dir_rows[i].typed)
            begin
                if (step_n != int'(dir_rows[i].n_out))
                begin
                    $error("row %0d result count: expected %0d, got %0d",
                           i, dir_rows[i].n_out, step_n);
                    errors++;
                end
                else if (step_n > 0 && step_last != dir_rows[i].last_byte)
                begin
                    $error("row %0d last out_byte: expected 8'h%02h, got 8'h%02h",
                           i, dir_rows[i].last_byte, step_last);
                    errors++;
                end
            end
        end

        // Random templates; the tail of the run goes without idling so that
        // both sides also see long back-to-back stretches.
        while (n_sent < N_DIR + 175)
        begin
            if (n_sent > N_DIR + 140)
                gaps_on = 1'b0;
            send_template();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        wait_cycles = 0;
        while (src_expect_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);

        if (src_expect_q.size() != 0)
        begin
            $error("%0d expected output bytes never arrived", src_expect_q.size());
            errors++;
        end

        $display("Sent %0d input transactions across %0d random templates plus directed rows,",
                 n_sent, n_templates);
        $display("and checked %0d output bytes with their run markers.", n_checked);
        if (errors == 0)
            $display("template_tag_to_print_stream test passed");
        else
            $display("template_tag_to_print_stream test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts while idling is on.
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (gaps_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            m_tready <= (stall_left == 0);
        end
    end

    // Every output transaction is compared with the oldest expected byte.
    always @(posedge clk)
    begin
        logic [8:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (src_expect_q.size() == 0)
            begin
                $error("unexpected output transaction: out_byte 8'h%02h, last_of_run %0b",
                       m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = src_expect_q.pop_front();
                n_checked++;
                if (m_tdata !== want[7:0])
                begin
                    $error("out_byte: expected 8'h%02h, got 8'h%02h", want[7:0], m_tdata);
                    errors++;
                end
                if (m_tlast !== want[8])
                begin
                    $error("last_of_run: expected %0b, got %0b", want[8], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("template_tag_to_print_stream test failed");
        $finish;
    end

endmodule
